[sv/gaussian_smooth_3x3_unit_assert.svh]
// Assertion macros for the smoothing unit and its checker.
`ifndef GAUSSIAN_SMOOTH_3X3_UNIT_ASSERT_SVH
`define GAUSSIAN_SMOOTH_3X3_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GS3_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GS3_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/gs3_pkg.sv]
package gs3_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;
  localparam int SAMPLE_W  = 16;
  localparam int WEIGHT_W  = 16;
  localparam int POS_W     = 10;
  localparam int SUM_W     = SAMPLE_W + 2;
  localparam int ACC_W     = 36;
  localparam int MIN_WIDTH = 3;

  localparam logic [WIDTH_W-1:0]  MAP_WIDTH_RESET     = WIDTH_W'(256);
  localparam logic [WEIGHT_W-1:0] WEIGHT_CENTER_RESET = WEIGHT_W'(13383);
  localparam logic [WEIGHT_W-1:0] WEIGHT_EDGE_RESET   = WEIGHT_W'(8114);
  localparam logic [WEIGHT_W-1:0] WEIGHT_CORNER_RESET = WEIGHT_W'(4922);

  typedef enum logic [1:0] {
    REG_MAP_WIDTH     = 2'd0,
    REG_WEIGHT_CENTER = 2'd1,
    REG_WEIGHT_EDGE   = 2'd2,
    REG_WEIGHT_CORNER = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [ADDR_W-1:0] row;
    logic [ADDR_W-1:0] col;
    logic              last;
  } pos_t;

endpackage

[sv/gaussian_smooth_3x3_unit.sv]
// 3x3 Gaussian smoothing of a square height map streamed in raster order.
// One sample is taken every cycle while in_stall is low, with no gaps at row
// or map boundaries; the interior result for window centre (r-1, c-1) passes
// from the sample at (r, c) through the pipeline registers. The rate is set
// by the single line memory (upper and middle rows side by side), read as a
// sample enters and written back from the stage-1 registers; a write-to-read
// forward covers a repeated column after frame_start. Border positions give
// no result. in_stall rises only once the two-entry output buffer is full.
module gaussian_smooth_3x3_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  gs3_pkg::reg_index_t                 cfg_index,
  input  logic [gs3_pkg::WEIGHT_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gs3_pkg::SAMPLE_W-1:0]        sample,
  input  logic                                frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gs3_pkg::SAMPLE_W-1:0]        smoothed,
  output logic [gs3_pkg::POS_W-1:0]           out_row,
  output logic [gs3_pkg::POS_W-1:0]           out_col,
  output logic                                frame_last
);

  localparam int AW = gs3_pkg::ADDR_W;
  localparam int SW = gs3_pkg::SAMPLE_W;
  localparam int WW = gs3_pkg::WIDTH_W;
  localparam int UW = gs3_pkg::SUM_W;
  localparam int KW = gs3_pkg::WEIGHT_W;
  localparam int XW = gs3_pkg::ACC_W;

  // config
  logic [WW-1:0] map_width;
  logic [KW-1:0] weight_center, weight_edge, weight_corner;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width     <= gs3_pkg::MAP_WIDTH_RESET;
      weight_center <= gs3_pkg::WEIGHT_CENTER_RESET;
      weight_edge   <= gs3_pkg::WEIGHT_EDGE_RESET;
      weight_corner <= gs3_pkg::WEIGHT_CORNER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        gs3_pkg::REG_MAP_WIDTH:     map_width     <= cfg_data[WW-1:0];
        gs3_pkg::REG_WEIGHT_CENTER: weight_center <= cfg_data;
        gs3_pkg::REG_WEIGHT_EDGE:   weight_edge   <= cfg_data;
        gs3_pkg::REG_WEIGHT_CORNER: weight_corner <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w_eff;
  always_comb begin
    if (map_width < WW'(gs3_pkg::MIN_WIDTH)) w_eff = WW'(gs3_pkg::MIN_WIDTH);
    else if (map_width > WW'(gs3_pkg::MAX_WIDTH)) w_eff = WW'(gs3_pkg::MAX_WIDTH);
    else w_eff = map_width;
  end

  // pipeline control
  logic skid_valid;
  logic en, accept;
  assign en       = !skid_valid;
  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  // stage 0: position and memory read
  logic [AW-1:0] row, col;
  logic [AW-1:0] row_cur, col_cur, row_next, col_next;
  logic          emit0, last0;

  always_comb begin
    row_cur = frame_start ? '0 : row;
    col_cur = frame_start ? '0 : col;
    emit0   = (row_cur >= AW'(2)) && (col_cur >= AW'(2));
    last0   = (WW'(row_cur) == w_eff - WW'(1)) && (WW'(col_cur) == w_eff - WW'(1));
    if (WW'(col_cur) + WW'(1) >= w_eff) begin
      col_next = '0;
      row_next = (WW'(row_cur) + WW'(1) >= w_eff) ? '0 : row_cur + AW'(1);
    end else begin
      col_next = col_cur + AW'(1);
      row_next = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

  // line memory: [2*SW-1:SW] upper row, [SW-1:0] middle row
  logic [2*SW-1:0] line_mem [gs3_pkg::MAX_WIDTH];
  logic [2*SW-1:0] rd_word;

  // stage 1 registers
  logic            v1, emit1;
  logic [AW-1:0]   addr1;
  logic [SW-1:0]   samp1;
  gs3_pkg::pos_t   pos1;
  logic            fwd1;
  logic [2*SW-1:0] fwd_word1;

  logic [2*SW-1:0] word1;
  logic [SW-1:0]   top1, mid1;
  assign word1 = fwd1 ? fwd_word1 : rd_word;
  assign top1  = word1[2*SW-1:SW];
  assign mid1  = word1[SW-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word <= line_mem[col_cur];
    end
    if (en && v1) begin
      line_mem[addr1] <= {mid1, samp1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emit1     <= emit0;
      addr1     <= col_cur;
      samp1     <= sample;
      pos1.row  <= row_cur - AW'(1);
      pos1.col  <= col_cur - AW'(1);
      pos1.last <= last0;
      fwd1      <= v1 && (addr1 == col_cur);
      fwd_word1 <= {mid1, samp1};
    end
  end

  // window: taps 0..2 column c-2 (top, mid, bottom), 3..5 column c-1
  logic [SW-1:0] taps [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) taps[i] <= '0;
    end else if (en && v1) begin
      taps[0] <= taps[3];
      taps[1] <= taps[4];
      taps[2] <= taps[5];
      taps[3] <= top1;
      taps[4] <= mid1;
      taps[5] <= samp1;
    end
  end

  logic [UW-1:0] corners1, edges1;
  assign corners1 = UW'(taps[0]) + UW'(taps[2]) + UW'(top1) + UW'(samp1);
  assign edges1   = UW'(taps[1]) + UW'(taps[3]) + UW'(taps[5]) + UW'(mid1);

  // stage 2: tap sums
  logic          v2;
  logic [SW-1:0] center2;
  logic [UW-1:0] edges2, corners2;
  gs3_pkg::pos_t pos2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1 && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      center2  <= taps[4];
      edges2   <= edges1;
      corners2 <= corners1;
      pos2     <= pos1;
    end
  end

  // stage 3: products
  logic            v3;
  logic [SW+KW-1:0] prod_c3;
  logic [UW+KW-1:0] prod_e3, prod_k3;
  gs3_pkg::pos_t   pos3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_c3 <= weight_center * center2;
      prod_e3 <= weight_edge * edges2;
      prod_k3 <= weight_corner * corners2;
      pos3    <= pos2;
    end
  end

  // final sum, round half up, saturate
  logic [XW-1:0]      acc3;
  logic [XW-16-1:0]   rnd3;
  logic [SW-1:0]      res3;
  assign acc3 = XW'(prod_c3) + XW'(prod_e3) + XW'(prod_k3) + XW'(32768);
  assign rnd3 = acc3[XW-1:16];
  assign res3 = (rnd3 > (XW-16)'(16'hFFFF)) ? '1 : rnd3[SW-1:0];

  // output register and skid entry
  logic          out_take;
  logic [SW-1:0] skid_val;
  gs3_pkg::pos_t skid_pos, out_pos;
  assign out_take = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        smoothed   <= skid_val;
        out_pos    <= skid_pos;
        skid_valid <= 1'b0;
      end
    end else if (v3) begin
      if (!out_valid || out_take) begin
        smoothed  <= res3;
        out_pos   <= pos3;
        out_valid <= 1'b1;
      end else begin
        skid_val   <= res3;
        skid_pos   <= pos3;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign out_row    = gs3_pkg::POS_W'(out_pos.row);
  assign out_col    = gs3_pkg::POS_W'(out_pos.col);
  assign frame_last = out_pos.last;

endmodule

[sv/gs3_checker.sv]
`include "gaussian_smooth_3x3_unit_assert.svh"

module gs3_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [gs3_pkg::SAMPLE_W-1:0] smoothed,
  input logic [gs3_pkg::POS_W-1:0]    out_row,
  input logic [gs3_pkg::POS_W-1:0]    out_col,
  input logic                         frame_last
);

  // held request must not move while stalled
  `GS3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(smoothed) && $stable(out_row) && $stable(out_col), "result changed while stalled")

  // input back-pressure only follows a stalled output
  `GS3_ASSERT_NOW(a_stall_cause, in_stall, $past(out_valid && out_stall), "input stalled without output back-pressure")

  // interior positions only
  `GS3_ASSERT_NOW(a_interior, out_valid, out_row != '0 && out_col != '0, "border position emitted")

  // last result sits on the diagonal corner
  `GS3_ASSERT_NOW(a_last_diag, out_valid && frame_last, out_row == out_col, "frame_last off the diagonal")

endmodule

bind gaussian_smooth_3x3_unit gs3_checker u_gs3_checker (.*);
